[sv/qpb_pkg.sv]
`default_nettype none
package qpb_pkg;

  // defaults for the top level parameters
  localparam int TREE_DEPTH_DEF    = 3;
  localparam int LEAF_CAPACITY_DEF = 16;

  // a report streams at most this many members
  localparam int MAX_REPORT = 16;

  // port widths fixed by the item fields
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    OUT_INS = 2'd0,
    OUT_NOG = 2'd1,
    OUT_MEM = 2'd2
  } out_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     step;
    logic     leaf_rd;
    logic     leaf_wr;
    logic     leaf_inc;
    logic     rep_rd;
    logic     rep_latch;
    logic     mem_rd;
    logic     k_inc;
    logic     clr_all;
    out_sel_t out_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic lvl_last;
    logic leaf_last;
    logic few;
    logic k_last;
  } status_t;

  // saturate a count to seven bits
  function automatic logic [6:0] sat7(input logic [15:0] v);
    if (v > 16'd127) begin
      return 7'd127;
    end
    return v[6:0];
  endfunction

endpackage
`default_nettype wire

[sv/qpb_ctrl.sv]
`default_nettype none
module qpb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_action,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_last,
  input  wire qpb_pkg::status_t stat,
  output qpb_pkg::cmd_t         cmd
);
  import qpb_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DESC = 10'b00_0000_0010,
    S_LRD  = 10'b00_0000_0100,
    S_LWR  = 10'b00_0000_1000,
    S_RESP = 10'b00_0001_0000,
    S_RCNT = 10'b00_0010_0000,
    S_RCHK = 10'b00_0100_0000,
    S_NOG  = 10'b00_1000_0000,
    S_MRD  = 10'b01_0000_0000,
    S_MOUT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  act_t   act;

  assign act = act_t'(in_action);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_sel = OUT_INS;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (act)
            ACT_INSERT: begin
              cmd.load  = 1'b1;
              state_nxt = S_DESC;
            end
            ACT_REPORT: begin
              cmd.load  = 1'b1;
              state_nxt = S_RCNT;
            end
            ACT_CLEAR: cmd.clr_all = 1'b1;
            default: ;
          endcase
        end
      end
      S_DESC: begin
        cmd.step = 1'b1;
        if (stat.lvl_last) state_nxt = S_LRD;
      end
      S_LRD: begin
        cmd.leaf_rd = 1'b1;
        state_nxt   = S_LWR;
      end
      S_LWR: begin
        cmd.leaf_wr = 1'b1;
        if (stat.leaf_last) begin
          state_nxt = S_RESP;
        end else begin
          cmd.leaf_inc = 1'b1;
          state_nxt    = S_LRD;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        cmd.out_sel = OUT_INS;
        if (out_ready) state_nxt = S_IDLE;
      end
      S_RCNT: begin
        cmd.rep_rd = 1'b1;
        state_nxt  = S_RCHK;
      end
      S_RCHK: begin
        cmd.rep_latch = 1'b1;
        state_nxt = stat.few ? S_NOG : S_MRD;
      end
      S_NOG: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        cmd.out_sel = OUT_NOG;
        if (out_ready) state_nxt = S_IDLE;
      end
      S_MRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_MOUT;
      end
      S_MOUT: begin
        out_valid = 1'b1;
        out_last  = stat.k_last;
        cmd.out_sel = OUT_MEM;
        if (out_ready) begin
          if (stat.k_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_MRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/qpb_datapath.sv]
`default_nettype none
module qpb_datapath #(
  parameter int TREE_DEPTH    = qpb_pkg::TREE_DEPTH_DEF,
  parameter int LEAF_CAPACITY = qpb_pkg::LEAF_CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire qpb_pkg::cmd_t                    cmd,
  output qpb_pkg::status_t                      stat,
  input  wire logic                             cfg_we,
  input  wire logic [qpb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [qpb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [qpb_pkg::IN_DATA_W-1:0]    in_data,
  output logic      [qpb_pkg::OUT_DATA_W-1:0]   out_data
);
  import qpb_pkg::*;

  localparam int GS    = 1 << TREE_DEPTH;
  localparam int NL    = GS * GS;
  localparam int LF_W  = 2 * TREE_DEPTH;
  localparam int LVL_W = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
  localparam int CW    = $clog2(LEAF_CAPACITY + 1);
  localparam int MA_W  = $clog2(NL * LEAF_CAPACITY);
  localparam int JW    = LF_W + 1;
  localparam int NW    = $clog2(MAX_REPORT + 1);

  // configuration registers
  logic signed [31:0] left_r, top_r;
  logic [30:0]        width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= 31'd65536;
      height_r <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LEFT:   left_r   <= cfg_wdata;
        REG_TOP:    top_r    <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata[30:0];
        REG_HEIGHT: height_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // captured item and disc spans
  logic [15:0]        id_r;
  logic [5:0]         sel_r;
  logic signed [33:0] lox_r, hix_r, loy_r, hiy_r;
  logic signed [33:0] px_e, py_e, rad_e;

  assign px_e  = $signed({{2{in_data[47]}}, in_data[47:16]});
  assign py_e  = $signed({{2{in_data[79]}}, in_data[79:48]});
  assign rad_e = $signed({3'b000, in_data[110:80]});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r  <= in_data[15:0];
      sel_r <= in_data[116:111];
      lox_r <= px_e - rad_e;
      hix_r <= px_e + rad_e;
      loy_r <= py_e - rad_e;
      hiy_r <= py_e + rad_e;
    end
  end

  // descent lanes, one per column and one per row, one level per cycle
  logic [LVL_W-1:0]   lvl_r;
  logic signed [33:0] ox_r[GS];
  logic signed [33:0] oy_r[GS];
  logic [GS-1:0]      colok_r, rowok_r;
  logic signed [33:0] midx[GS];
  logic signed [33:0] midy[GS];
  logic [GS-1:0]      bsel;
  logic [LVL_W:0]     shamt;
  logic [LVL_W-1:0]   bidx;
  logic signed [33:0] halfx, halfy;

  assign shamt = (LVL_W+1)'(lvl_r) + (LVL_W+1)'(1);
  assign bidx  = LVL_W'(TREE_DEPTH - 1) - lvl_r;
  assign halfx = $signed({3'b000, width_r >> shamt});
  assign halfy = $signed({3'b000, height_r >> shamt});

  always_comb begin
    for (int i = 0; i < GS; i++) begin
      bsel[i] = 1'(TREE_DEPTH'(i) >> bidx);
      midx[i] = ox_r[i] + halfx;
      midy[i] = oy_r[i] - halfy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else if (cmd.load) begin
      lvl_r <= '0;
    end else if (cmd.step) begin
      lvl_r <= lvl_r + LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < GS; i++) begin
      if (cmd.load) begin
        ox_r[i]    <= {{2{left_r[31]}}, left_r};
        oy_r[i]    <= {{2{top_r[31]}}, top_r};
        colok_r[i] <= 1'b1;
        rowok_r[i] <= 1'b1;
      end else if (cmd.step) begin
        if (!bsel[i]) begin
          colok_r[i] <= colok_r[i] & (lox_r < midx[i]);
          rowok_r[i] <= rowok_r[i] & (hiy_r > midy[i]);
        end else begin
          colok_r[i] <= colok_r[i] & (hix_r > midx[i]);
          rowok_r[i] <= rowok_r[i] & (loy_r < midy[i]);
          ox_r[i]    <= midx[i];
          oy_r[i]    <= midy[i];
        end
      end
    end
  end

  assign stat.lvl_last = (lvl_r == LVL_W'(TREE_DEPTH - 1));

  // leaf sweep
  logic [LF_W-1:0]       lf_r;
  logic [JW-1:0]         joined_r, full_r;
  logic                  reach;
  logic [TREE_DEPTH-1:0] lf_row, lf_col;

  assign lf_row = lf_r[LF_W-1 -: TREE_DEPTH];
  assign lf_col = lf_r[TREE_DEPTH-1:0];
  assign reach  = rowok_r[lf_row] & colok_r[lf_col];
  assign stat.leaf_last = (lf_r == {LF_W{1'b1}});

  // leaf count memory with per-leaf valid bits
  logic [CW-1:0]   cnt_mem[NL];
  logic [NL-1:0]   cvld_r;
  logic [CW-1:0]   cnt_q_r;
  logic            cv_q_r;
  logic [CW-1:0]   cnt_val;
  logic [LF_W-1:0] sel_leaf, cnt_raddr;
  logic            has_room;

  assign sel_leaf  = LF_W'(sel_r);
  assign cnt_raddr = cmd.leaf_rd ? lf_r : sel_leaf;
  assign cnt_val   = cv_q_r ? cnt_q_r : '0;
  assign has_room  = cnt_val < CW'(LEAF_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
    end else if (cmd.clr_all) begin
      cvld_r <= '0;
    end else if (cmd.leaf_wr && reach && has_room) begin
      cvld_r[lf_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.leaf_rd || cmd.rep_rd) begin
      cnt_q_r <= cnt_mem[cnt_raddr];
      cv_q_r  <= cvld_r[cnt_raddr];
    end
    if (cmd.leaf_wr && reach && has_room) begin
      cnt_mem[lf_r] <= cnt_val + CW'(1);
    end
  end

  // member memory
  logic [15:0]     mem[NL * LEAF_CAPACITY];
  logic [15:0]     mq_r;
  logic [MA_W-1:0] waddr, maddr;
  logic [NW-1:0]   k_r, n_r, nval;
  logic            sel_bad;

  assign waddr = MA_W'(lf_r) * MA_W'(LEAF_CAPACITY) + MA_W'(cnt_val);
  assign maddr = MA_W'(sel_leaf) * MA_W'(LEAF_CAPACITY) + MA_W'(k_r);

  always_ff @(posedge clk) begin
    if (cmd.leaf_wr && reach && has_room) begin
      mem[waddr] <= id_r;
    end
    if (cmd.mem_rd) begin
      mq_r <= mem[maddr];
    end
  end

  // sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_r     <= '0;
      joined_r <= '0;
      full_r   <= '0;
    end else if (cmd.load) begin
      lf_r     <= '0;
      joined_r <= '0;
      full_r   <= '0;
    end else begin
      if (cmd.leaf_inc) lf_r <= lf_r + LF_W'(1);
      if (cmd.leaf_wr && reach) begin
        if (has_room) joined_r <= joined_r + JW'(1);
        else          full_r   <= full_r + JW'(1);
      end
    end
  end

  // report member count, leaves beyond the grid read as empty
  assign sel_bad = int'(sel_r) >= NL;

  always_comb begin
    if (sel_bad) begin
      nval = '0;
    end else if (int'(cnt_val) > MAX_REPORT) begin
      nval = NW'(MAX_REPORT);
    end else begin
      nval = NW'(cnt_val);
    end
  end

  assign stat.few = nval < NW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      n_r <= '0;
    end else if (cmd.rep_latch) begin
      k_r <= '0;
      n_r <= nval;
    end else if (cmd.k_inc) begin
      k_r <= k_r + NW'(1);
    end
  end

  assign stat.k_last = ((k_r + NW'(1)) == n_r);

  // result packing
  always_comb begin
    out_data = '0;
    case (cmd.out_sel)
      OUT_INS: begin
        out_data[23:17] = sat7(16'(joined_r));
        out_data[30:24] = sat7(16'(full_r));
      end
      OUT_NOG: out_data[16] = 1'b1;
      OUT_MEM: out_data[15:0] = mq_r;
      default: out_data = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/quadtree_particle_binning.sv]
// insert: takes the item, descends one tree level per step, then sweeps the
//   leaves with a count memory read and a write for every leaf of the grid
// report: count read and check, then a member memory read and an output per member
// clear: done on acceptance, ready again the next cycle; one item is in work at a time
// synchronous active-low reset: registers to reset values, all leaves empty at once
`default_nettype none
module quadtree_particle_binning #(
  parameter int TREE_DEPTH    = qpb_pkg::TREE_DEPTH_DEF,
  parameter int LEAF_CAPACITY = qpb_pkg::LEAF_CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // particle_id[15:0], pos_x[47:16], pos_y[79:48], radius[110:80], leaf_select[116:111]
  input  wire logic [qpb_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  wire logic [1:0]                     in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // member_id[15:0], no_group[16], leaves_joined[23:17], leaves_full[30:24]
  output logic [qpb_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [qpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qpb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qpb_pkg::*;

  cmd_t    cmd;
  status_t stat;

  assign cfg_ready = 1'b1;

  qpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_last  (out_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  qpb_datapath #(
    .TREE_DEPTH    (TREE_DEPTH),
    .LEAF_CAPACITY (LEAF_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_data   (in_tdata),
    .out_data  (out_tdata)
  );

  // no new item while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

  // a count write always follows its read
  a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.leaf_wr |-> $past(cmd.leaf_rd))
    else $error("leaf write without read");

  // a member read is shown the next cycle
  a_mem_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |=> out_tvalid)
    else $error("member read not presented");

  // final result returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not idle after last result");

endmodule
`default_nettype wire

[verif/quadtree_particle_binning_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module quadtree_particle_binning_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [qpb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]                     in_tuser,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [qpb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           out_tlast,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [qpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qpb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  result_count
);
  import qpb_pkg::*;

  localparam int SIDE = 8;
  localparam int LEAVES = 64;
  localparam int CAP = 16;

  typedef struct packed {
    logic [15:0] member_id;
    logic        no_group;
    logic [6:0]  joined;
    logic [6:0]  full;
    logic        last;
  } bin_res_t;

  logic signed [63:0] bound_left, bound_top;
  logic [63:0]        bound_w, bound_h;
  int                 bin_fill [LEAVES];
  logic [15:0]        bin_ids  [LEAVES][CAP];
  bin_res_t           expected_q [$];

  // append one expected result at the tail
  function automatic void queue_expect(input bin_res_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  // which grid positions a span reaches along one axis
  function automatic logic [SIDE-1:0] span_reach(input logic signed [63:0] org,
      input logic [63:0] ext, input logic signed [63:0] lo,
      input logic signed [63:0] hi, input bit falling);
    logic [SIDE-1:0]    ok;
    logic signed [63:0] o, half, mid;
    bit                 good, b;
    for (int i = 0; i < SIDE; i++) begin
      o = org;
      good = 1;
      for (int l = 0; l < 3 && good; l++) begin
        half = $signed(ext >> (l + 1));
        b = (i >> (2 - l)) & 1;
        mid = falling ? o - half : o + half;
        if (!falling) begin
          if (!b) good = lo < mid;
          else begin good = hi > mid; o = mid; end
        end else begin
          if (!b) good = hi > mid;
          else begin good = lo < mid; o = mid; end
        end
      end
      ok[i] = good;
    end
    return ok;
  endfunction

  // predict the results of one accepted item
  task automatic bin_item(input logic [1:0] act, input logic [119:0] d);
    logic signed [63:0] px, py, r;
    logic [SIDE-1:0]    cols, rows;
    int                 joined, full, leaf, n;
    bin_res_t           res;
    res = '0;
    case (act)
      ACT_INSERT: begin
        px = $signed(d[47:16]);
        py = $signed(d[79:48]);
        r = {33'd0, d[110:80]};
        cols = span_reach(bound_left, bound_w, px - r, px + r, 0);
        rows = span_reach(bound_top, bound_h, py - r, py + r, 1);
        joined = 0;
        full = 0;
        for (int row = 0; row < SIDE; row++)
          for (int col = 0; col < SIDE; col++)
            if (rows[row] && cols[col]) begin
              leaf = row * SIDE + col;
              if (bin_fill[leaf] < CAP) begin
                bin_ids[leaf][bin_fill[leaf]] = d[15:0];
                bin_fill[leaf]++;
                joined++;
              end else full++;
            end
        res.joined = joined;
        res.full = full;
        res.last = 1;
        queue_expect(res);
      end
      ACT_REPORT: begin
        leaf = d[116:111];
        n = bin_fill[leaf];
        if (n < 2) begin
          res.no_group = 1;
          res.last = 1;
          queue_expect(res);
        end else begin
          if (n > MAX_REPORT) n = MAX_REPORT;
          for (int k = 0; k < n; k++) begin
            res = '0;
            res.member_id = bin_ids[leaf][k];
            res.last = (k == n - 1);
            queue_expect(res);
          end
        end
      end
      ACT_CLEAR: foreach (bin_fill[i]) bin_fill[i] = 0;
      default: ;
    endcase
  endtask

  // watch all channels
  always @(posedge clk) begin
    bin_res_t got, exp_r;
    if (!rst_n) begin
      bound_left <= 0;
      bound_top <= 0;
      bound_w = 65536;
      bound_h = 65536;
      foreach (bin_fill[i]) bin_fill[i] = 0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT:   bound_left <= $signed(cfg_data);
          REG_TOP:    bound_top <= $signed(cfg_data);
          REG_WIDTH:  bound_w = {33'd0, cfg_data[30:0]};
          REG_HEIGHT: bound_h = {33'd0, cfg_data[30:0]};
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) bin_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[16], out_tdata[23:17], out_tdata[30:24], out_tlast};
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r || out_tdata[31] !== 1'b0) begin
            $display("%0t mismatch expected id=%h nog=%b j=%0d f=%0d last=%b",
                     $time, exp_r.member_id, exp_r.no_group, exp_r.joined, exp_r.full,
                     exp_r.last);
            $display("%0t          actual   id=%h nog=%b j=%0d f=%0d last=%b",
                     $time, got.member_id, got.no_group, got.joined, got.full, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = expected_q.size();
  end
endmodule
`default_nettype wire

[verif/quadtree_particle_binning_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module quadtree_particle_binning_tb;
  import qpb_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic [119:0] in_tdata = '0;
  logic [1:0]   in_tuser = ACT_CLEAR;
  logic         in_tvalid = 0;
  wire          in_tready;
  wire  [31:0]  out_tdata;
  wire          out_tlast, out_tvalid, cfg_ready;
  logic         out_tready = 0;
  logic         cfg_valid = 0;
  logic [1:0]   cfg_index = REG_LEFT;
  logic [31:0]  cfg_data = '0;
  int           fail_count, pending_count, result_count;
  int           idle_cycles = 0;
  bit           calm_phase = 0;
  bit           hold_rx = 0;

  quadtree_particle_binning u_top (.*);

  quadtree_particle_binning_checker u_chk (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver with random stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_rx) out_tready <= 0;
      else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk);
      end else out_tready <= 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_region(input logic [31:0] l, t, w, h);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic send_item(input logic [1:0] act, input logic [15:0] id,
      input logic [31:0] x, y, input logic [30:0] r, input logic [5:0] leaf);
    int n;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      in_tvalid <= 0;
      repeat (n) @(negedge clk);
    end
    in_tuser <= act;
    in_tdata <= {3'd0, leaf, r, y, x, id};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // random insert with x from 0 to span and y from -span to 0, mostly small discs
  task automatic rand_insert(input int span);
    logic [31:0] x, y;
    logic [30:0] r;
    x = $urandom_range(0, span);
    y = -$signed($urandom_range(0, span));
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span) : $urandom_range(0, span / 16);
    send_item(ACT_INSERT, $urandom, x, y, r, $urandom);
  endtask

  initial begin
    int pick;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: default region, edges of the fields
    send_item(ACT_REPORT, 0, 0, 0, 0, 6'd0);
    send_item(ACT_INSERT, 16'h0000, 32'h0000_8000, 32'hFFFF_8000, 31'd0, 0);
    send_item(ACT_INSERT, 16'hFFFF, 32'h0000_8000, 32'hFFFF_8000, 31'd1, 0);
    send_item(ACT_INSERT, 16'h1234, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 0);
    send_item(ACT_INSERT, 16'hABCD, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 0);
    send_item(ACT_INSERT, 16'h5555, 32'h0000_2000, 32'hFFFF_E000, 31'h0000_1000, 0);
    send_item(ACT_REPORT, 0, 0, 0, 0, 6'd27);
    send_item(ACT_REPORT, 0, 0, 0, 0, 6'd63);
    send_item(ACT_REPORT, 0, 0, 0, 0, 6'd0);
    send_item(ACT_NONE, 16'hFFFF, '1, '1, '1, '1);
    // overfill every leaf so full counts and long reports appear
    repeat (18) send_item(ACT_INSERT, $urandom, 32'h0000_8000, 32'hFFFF_8000, 31'h0001_0000, 0);
    send_item(ACT_REPORT, 0, 0, 0, 0, 6'd9);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
    send_item(ACT_REPORT, 0, 0, 0, 0, 6'd9);
    in_tvalid <= 0;
    wait_drained();

    // extremes of the region registers
    set_region(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 16'h0001, 32'h0000_0000, 32'h0000_0000, 31'd5, 0);
    send_item(ACT_INSERT, 16'h0002, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 0);
    send_item(ACT_REPORT, 0, 0, 0, 0, 6'd0);
    in_tvalid <= 0;
    wait_drained();
    set_region(32'h0000_0000, 32'h0000_0000, 32'd1, 32'd1);
    send_item(ACT_INSERT, 16'h0003, 32'd0, 32'd0, 31'd0, 0);
    send_item(ACT_INSERT, 16'h0004, 32'd0, 32'd0, 31'd1, 0);
    in_tvalid <= 0;
    wait_drained();

    // back pressure: receiver holds while inserts pile up
    set_region(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
    hold_rx = 1;
    fork
      begin repeat (600) @(negedge clk); hold_rx = 0; end
      repeat (6) rand_insert(32'h0001_0000);
    join
    in_tvalid <= 0;
    wait_drained();

    // random: several region settings, mostly well-formed inserts and reports
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) calm_phase = 1;
      set_region($urandom, $urandom, $urandom_range(1024, 32'h0010_0000),
                 $urandom_range(1024, 32'h0010_0000));
      write_reg(REG_LEFT, 0);
      write_reg(REG_TOP, 0);
      for (int i = 0; i < 42; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) rand_insert(32'h0008_0000);
        else if (pick < 17) send_item(ACT_REPORT, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 18) send_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, 0);
        else if (pick < 19) send_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        else send_item(ACT_INSERT, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      in_tvalid <= 0;
      wait_drained();
    end

    $display("covered inserts, reports, clears and ignored codes over several regions,");
    $display("with full leaves, back pressure and %0d results checked", result_count);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
